/* rtl/qer_pkg.sv */
package qer_pkg;

  localparam int CoefWidth  = 16;
  localparam int FracBits   = 8;
  localparam int RootFrac   = 16;
  localparam int PolyWidth  = 48;
  localparam int RootWidth  = 32;
  localparam int DiscWidth  = 2 * CoefWidth + 3;
  localparam int SqrtWidth  = (DiscWidth + 1) / 2;
  localparam int NumWidth   = SqrtWidth + 2;
  localparam int ShNumWidth = NumWidth + RootFrac;
  localparam int DenWidth   = CoefWidth + 1;
  localparam int QuoWidth   = ShNumWidth;
  localparam int CountWidth = 2;

  localparam logic [CountWidth-1:0] ZcNone = 2'd0;
  localparam logic [CountWidth-1:0] ZcOne  = 2'd1;
  localparam logic [CountWidth-1:0] ZcTwo  = 2'd2;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_a;
    logic signed [CoefWidth-1:0] coef_b;
    logic signed [CoefWidth-1:0] coef_c;
    logic signed [CoefWidth-1:0] point_x;
  } qer_in_t;

  typedef struct packed {
    logic signed [PolyWidth-1:0] poly_value;
    logic [CountWidth-1:0]       zero_count;
    logic signed [RootWidth-1:0] root_plus;
    logic signed [RootWidth-1:0] root_minus;
    logic                        degenerate;
    logic                        root_saturated;
  } qer_out_t;

  // Side information that travels with an item through the root pipeline.
  typedef struct packed {
    logic signed [PolyWidth-1:0] poly_value;
    logic [CountWidth-1:0]       zero_count;
    logic                        degenerate;
    logic                        roots_on;
  } qer_side_t;

endpackage

/* rtl/qer_if.sv */
interface qer_in_if import qer_pkg::*; ();
  logic    valid;
  logic    ready;
  qer_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qer_out_if import qer_pkg::*; ();
  logic     valid;
  logic     ready;
  qer_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/qer_front.sv */
// Two stages: products, then sums. Produces the discriminant and polynomial.
module qer_front import qer_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  qer_in_t                     in_data,
  output logic                        out_valid,
  output logic signed [DiscWidth-1:0] out_disc,
  output logic signed [CoefWidth-1:0] out_a,
  output logic signed [CoefWidth-1:0] out_b,
  output logic signed [PolyWidth-1:0] out_poly
);

  localparam int PW = 2 * CoefWidth;

  logic                        v1_r, v2_r;
  logic signed [PW-1:0]        ax_r, bx_r, bb_r, ac_r;
  logic signed [CoefWidth-1:0] a1_r, b1_r, c1_r, x1_r;
  logic signed [DiscWidth-1:0] disc_r;
  logic signed [CoefWidth-1:0] a2_r, b2_r;
  logic signed [PolyWidth-1:0] poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_data.coef_a * in_data.point_x;
      bx_r <= in_data.coef_b * in_data.point_x;
      bb_r <= in_data.coef_b * in_data.coef_b;
      ac_r <= in_data.coef_a * in_data.coef_c;
      a1_r <= in_data.coef_a;
      b1_r <= in_data.coef_b;
      c1_r <= in_data.coef_c;
      x1_r <= in_data.point_x;
      a2_r <= a1_r;
      b2_r <= b1_r;
      disc_r <= DiscWidth'(bb_r) - (DiscWidth'(ac_r) <<< 2);
      poly_r <= PolyWidth'(ax_r * x1_r) + (PolyWidth'(bx_r) <<< FracBits)
                + (PolyWidth'(c1_r) <<< (2 * FracBits));
    end
  end

  assign out_valid = v2_r;
  assign out_disc  = disc_r;
  assign out_a     = a2_r;
  assign out_b     = b2_r;
  assign out_poly  = poly_r;

endmodule

/* rtl/qer_sqrt.sv */
// Pipelined digit-by-digit square root, one result bit per stage.
module qer_sqrt import qer_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DiscWidth-1:0]  rad,
  output logic [SqrtWidth-1:0]  root
);

  localparam int RW = 2 * SqrtWidth;

  logic [RW-1:0]        rem_r  [SqrtWidth+1];
  logic [SqrtWidth-1:0] q_r    [SqrtWidth+1];
  logic [RW-1:0]        val_r  [SqrtWidth+1];

  always_comb begin
    rem_r[0] = '0;
    q_r[0]   = '0;
    val_r[0] = RW'(rad);
  end

  for (genvar i = 0; i < SqrtWidth; i++) begin : g_st
    logic [RW-1:0] rem_sh, trial;
    assign rem_sh = (rem_r[i] << 2) | RW'(val_r[i][RW-1 -: 2]);
    assign trial  = (RW'(q_r[i]) << 2) | RW'(1);
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[i+1] <= val_r[i] << 2;
        if (rem_sh >= trial) begin
          rem_r[i+1] <= rem_sh - trial;
          q_r[i+1]   <= (q_r[i] << 1) | SqrtWidth'(1);
        end else begin
          rem_r[i+1] <= rem_sh;
          q_r[i+1]   <= q_r[i] << 1;
        end
      end
    end
  end

  assign root = q_r[SqrtWidth];

endmodule

/* rtl/qer_div.sv */
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module qer_div import qer_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ShNumWidth-1:0] num,
  input  logic [DenWidth-1:0]  den,
  output logic [QuoWidth-1:0]  quo
);

  localparam int RW = DenWidth + 1;

  logic [RW-1:0]         rem_r [QuoWidth+1];
  logic [QuoWidth-1:0]   q_r   [QuoWidth+1];
  logic [DenWidth-1:0]   d_r   [QuoWidth+1];

  always_comb begin
    rem_r[0] = '0;
    q_r[0]   = num;
    d_r[0]   = den;
  end

  for (genvar i = 0; i < QuoWidth; i++) begin : g_st
    logic [RW-1:0] sh;
    assign sh = {rem_r[i][RW-2:0], q_r[i][QuoWidth-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i];
        if (sh >= RW'(d_r[i])) begin
          rem_r[i+1] <= sh - RW'(d_r[i]);
          q_r[i+1]   <= {q_r[i][QuoWidth-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh;
          q_r[i+1]   <= {q_r[i][QuoWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QuoWidth];

endmodule

/* rtl/quadratic_eval_and_roots.sv */
// Quadratic evaluator and root solver on Q8.8 inputs. One item per cycle while
// the output is not stalled; items pass the front stages, the bit-per-stage
// square root, the numerator stage, the bit-per-stage divider and the output
// register. A stalled output stalls the whole pipeline; no item is lost.
module quadratic_eval_and_roots import qer_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  qer_in_if.sink    in_ch,
  qer_out_if.source out_ch
);

  localparam int SqLat  = SqrtWidth;
  localparam int DivLat = QuoWidth;

  logic en;
  logic fv;
  logic signed [DiscWidth-1:0] disc;
  logic signed [CoefWidth-1:0] fa, fb;
  logic signed [PolyWidth-1:0] fpoly;
  logic [SqrtWidth-1:0] sroot;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  qer_front u_front (
    .clk, .rst_n, .en,
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data),
    .out_valid(fv), .out_disc(disc), .out_a(fa), .out_b(fb), .out_poly(fpoly)
  );

  qer_sqrt u_sqrt (
    .clk, .en,
    .rad (disc[DiscWidth-1] ? '0 : DiscWidth'(disc)),
    .root(sroot)
  );

  // Delay line alongside the square root.
  logic                        sv_r [SqLat+1];
  qer_side_t                   ss_r [SqLat+1];
  logic signed [CoefWidth-1:0] sa_r [SqLat+1];
  logic signed [CoefWidth-1:0] sb_r [SqLat+1];
  qer_side_t side0;

  always_comb begin
    side0.poly_value = fpoly;
    side0.zero_count = disc[DiscWidth-1] ? ZcNone : ((disc == '0) ? ZcOne : ZcTwo);
    side0.degenerate = (fa == '0);
    side0.roots_on   = (fa != '0) && !disc[DiscWidth-1];
    sv_r[0] = fv;
    ss_r[0] = side0;
    sa_r[0] = fa;
    sb_r[0] = fb;
  end

  for (genvar i = 0; i < SqLat; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[i+1] <= 1'b0;
      else if (en) sv_r[i+1] <= sv_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss_r[i+1] <= ss_r[i];
        sa_r[i+1] <= sa_r[i];
        sb_r[i+1] <= sb_r[i];
      end
    end
  end

  // Numerator stage: magnitudes and signs for both roots.
  logic signed [NumWidth-1:0] np, nm;
  logic [NumWidth-1:0] mp, mm;
  logic [DenWidth-1:0] dm;
  logic                nv_r;
  qer_side_t           ns_r;
  logic [ShNumWidth-1:0] mp_r, mm_r;
  logic [DenWidth-1:0] dm_r;
  logic                negp_r, negm_r;
  logic signed [DenWidth-1:0] den2;

  assign np   = -NumWidth'(sb_r[SqLat]) + NumWidth'(sroot);
  assign nm   = -NumWidth'(sb_r[SqLat]) - NumWidth'(sroot);
  assign mp   = np[NumWidth-1] ? NumWidth'(-np) : NumWidth'(np);
  assign mm   = nm[NumWidth-1] ? NumWidth'(-nm) : NumWidth'(nm);
  assign den2 = DenWidth'(sa_r[SqLat]) <<< 1;
  assign dm   = den2[DenWidth-1] ? DenWidth'(-den2) : DenWidth'(den2);

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 1'b0;
    else if (en) nv_r <= sv_r[SqLat];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns_r   <= ss_r[SqLat];
      mp_r   <= ShNumWidth'(mp) << RootFrac;
      mm_r   <= ShNumWidth'(mm) << RootFrac;
      dm_r   <= (dm == '0) ? DenWidth'(1) : dm;
      negp_r <= np[NumWidth-1] ^ den2[DenWidth-1];
      negm_r <= nm[NumWidth-1] ^ den2[DenWidth-1];
    end
  end

  logic [QuoWidth-1:0] qp, qm;

  qer_div u_divp (.clk, .en, .num(mp_r), .den(dm_r), .quo(qp));
  qer_div u_divm (.clk, .en, .num(mm_r), .den(dm_r), .quo(qm));

  logic      dv_r  [DivLat+1];
  qer_side_t ds_r  [DivLat+1];
  logic      dnp_r [DivLat+1];
  logic      dnm_r [DivLat+1];

  always_comb begin
    dv_r[0]  = nv_r;
    ds_r[0]  = ns_r;
    dnp_r[0] = negp_r;
    dnm_r[0] = negm_r;
  end

  for (genvar i = 0; i < DivLat; i++) begin : g_dd
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else if (en) dv_r[i+1] <= dv_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[i+1]  <= ds_r[i];
        dnp_r[i+1] <= dnp_r[i];
        dnm_r[i+1] <= dnm_r[i];
      end
    end
  end

  // Sign restore and clamp to Q16.16.
  localparam logic [QuoWidth-1:0] PosMax = QuoWidth'(32'h7fff_ffff);
  localparam logic [QuoWidth-1:0] NegMax = QuoWidth'(32'h8000_0000);

  logic [RootWidth-1:0] rp, rm;
  logic                 satp, satm;

  always_comb begin
    if (dnp_r[DivLat]) begin
      satp = qp > NegMax;
      rp   = satp ? RootWidth'(32'h8000_0000) : RootWidth'(-qp);
    end else begin
      satp = qp > PosMax;
      rp   = satp ? RootWidth'(32'h7fff_ffff) : RootWidth'(qp);
    end
    if (dnm_r[DivLat]) begin
      satm = qm > NegMax;
      rm   = satm ? RootWidth'(32'h8000_0000) : RootWidth'(-qm);
    end else begin
      satm = qm > PosMax;
      rm   = satm ? RootWidth'(32'h7fff_ffff) : RootWidth'(qm);
    end
  end

  logic     ov_r;
  qer_out_t od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= dv_r[DivLat];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      od_r.poly_value     <= ds_r[DivLat].poly_value;
      od_r.zero_count     <= ds_r[DivLat].zero_count;
      od_r.degenerate     <= ds_r[DivLat].degenerate;
      od_r.root_plus      <= ds_r[DivLat].roots_on ? rp : '0;
      od_r.root_minus     <= ds_r[DivLat].roots_on ? rm : '0;
      od_r.root_saturated <= ds_r[DivLat].roots_on && (satp || satm);
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

endmodule
